>>> rtl/mlq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlq_pkg: shared types and codes of the task scheduler
// Entry layout, scan wave, per-pass command, operation and pass codes.
// ----------------------------------------------------------------------------
package mlq_pkg;

  localparam int NumEntries = 16;

  // operations
  localparam logic [2:0] OP_CREATE    = 3'd0;
  localparam logic [2:0] OP_REMOVE    = 3'd1;
  localparam logic [2:0] OP_SET_LEVEL = 3'd2;
  localparam logic [2:0] OP_SET_STATE = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;
  localparam logic [2:0] OP_QUERY     = 3'd5;

  // run states
  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;

  localparam logic [1:0] LVL_DEFAULT = 2'd1;

  // result status
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_POLICY = 3'd0;
  localparam logic [2:0] CFG_TICK   = 3'd1;
  localparam logic [2:0] CFG_SLICE0 = 3'd2;
  localparam logic [2:0] CFG_SLICE1 = 3'd3;
  localparam logic [2:0] CFG_SLICE2 = 3'd4;
  localparam logic [2:0] CFG_SLICE3 = 3'd5;

  localparam logic [9:0] RST_TICK   = 10'd50;
  localparam logic [9:0] RST_SLICE0 = 10'd50;
  localparam logic [9:0] RST_SLICE1 = 10'd100;
  localparam logic [9:0] RST_SLICE2 = 10'd200;
  localparam logic [9:0] RST_SLICE3 = 10'd300;

  // scan passes
  localparam logic [2:0] PS_CREATE   = 3'd0;
  localparam logic [2:0] PS_FIND     = 3'd1;
  localparam logic [2:0] PS_CHARGE   = 3'd2;
  localparam logic [2:0] PS_PICK_MLQ = 3'd3;
  localparam logic [2:0] PS_PICK_RR  = 3'd4;
  localparam logic [2:0] PS_REPORT   = 3'd5;

  typedef struct packed {
    logic [15:0] pid;
    logic [1:0]  level;
    logic [1:0]  st;
    logic [9:0]  slice;
    logic [10:0] rem;
    logic [31:0] limit;
  } entry_t;

  // token that walks the chain, one cell per cycle
  typedef struct packed {
    logic        act;
    logic        hit;
    logic        flag;
    logic        cand;
    logic [1:0]  lvl;
    logic [31:0] data;
  } wave_t;

  typedef struct packed {
    logic [2:0]      pass;
    logic [2:0]      op;
    logic [15:0]     pid;
    logic [1:0]      lvl;
    logic [1:0]      st;
    logic [31:0]     lim;
    logic            pick_en;
    logic [1:0]      pick_lvl;
    logic            after;
    logic            mode;
    logic [9:0]      tick;
    logic [3:0][9:0] slices;
  } cmd_t;

endpackage

>>> rtl/mlq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlq_if: item channels of the task scheduler
// Command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mlq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [15:0] task_id;
  logic [1:0]  new_level;
  logic [1:0]  new_state;
  logic [31:0] mem_limit_in;

  modport source (output valid, operation, task_id, new_level, new_state, mem_limit_in,
                  input ready);
  modport sink (input valid, operation, task_id, new_level, new_state, mem_limit_in,
                output ready);
endinterface

interface mlq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        running_found;
  logic [15:0] running_id;
  logic [4:0]  task_count;
  logic [31:0] mem_limit_out;

  modport source (output valid, status, running_found, running_id, task_count,
                  mem_limit_out, input ready);
  modport sink (input valid, status, running_found, running_id, task_count,
                mem_limit_out, output ready);
endinterface

>>> rtl/mlq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlq_cell: one table entry of the scheduler
// Holds an entry and acts on it when the scan wave passes through.
// ----------------------------------------------------------------------------
module mlq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mlq_pkg::cmd_t   cmd_i,
  input  mlq_pkg::wave_t  wave_i,
  input  logic            nxt_valid_i,
  input  mlq_pkg::entry_t nxt_ent_i,
  output mlq_pkg::wave_t  wave_o,
  output logic            valid_o,
  output mlq_pkg::entry_t ent_o
);

  mlq_pkg::wave_t  wave_q, wave_d;
  mlq_pkg::entry_t ent_q, ent_d;
  logic            valid_q, valid_d;
  logic            charged_q, charged_d;
  logic [1:0]      lvl_up;

  assign lvl_up = ent_q.level - 2'd1;

  always_comb begin
    wave_d    = wave_i;
    valid_d   = valid_q;
    ent_d     = ent_q;
    charged_d = charged_q;
    if (wave_i.act) begin
      unique case (cmd_i.pass)
        mlq_pkg::PS_CREATE: begin
          if (!valid_q && !wave_i.hit) begin
            valid_d     = 1'b1;
            ent_d.pid   = cmd_i.pid;
            ent_d.level = mlq_pkg::LVL_DEFAULT;
            ent_d.st    = mlq_pkg::ST_READY;
            ent_d.slice = cmd_i.slices[mlq_pkg::LVL_DEFAULT];
            ent_d.rem   = {1'b0, cmd_i.slices[mlq_pkg::LVL_DEFAULT]};
            ent_d.limit = cmd_i.lim;
            wave_d.hit  = 1'b1;
          end
        end
        mlq_pkg::PS_FIND: begin
          if (valid_q && ent_q.pid == cmd_i.pid && !wave_i.hit) begin
            wave_d.hit = 1'b1;
            case (cmd_i.op)
              mlq_pkg::OP_REMOVE: begin
                valid_d = nxt_valid_i;
                ent_d   = nxt_ent_i;
              end
              mlq_pkg::OP_SET_LEVEL: begin
                ent_d.level = cmd_i.lvl;
                ent_d.slice = cmd_i.slices[cmd_i.lvl];
                ent_d.rem   = {1'b0, cmd_i.slices[cmd_i.lvl]};
              end
              mlq_pkg::OP_SET_STATE: begin
                ent_d.st = (cmd_i.st == mlq_pkg::ST_READY || cmd_i.st == mlq_pkg::ST_RUNNING)
                         ? cmd_i.st : mlq_pkg::ST_BLOCKED;
              end
              mlq_pkg::OP_QUERY: wave_d.data = ent_q.limit;
              default: ;
            endcase
          end else if (wave_i.hit && cmd_i.op == mlq_pkg::OP_REMOVE) begin
            // entries behind the removed one close up
            valid_d = nxt_valid_i;
            ent_d   = nxt_ent_i;
          end
        end
        mlq_pkg::PS_CHARGE: begin
          charged_d = 1'b0;
          if (valid_q && ent_q.st == mlq_pkg::ST_RUNNING && !wave_i.hit) begin
            wave_d.hit = 1'b1;
            charged_d  = 1'b1;
            if (ent_q.rem <= {1'b0, cmd_i.tick}) begin
              wave_d.flag = 1'b1;
              ent_d.st    = mlq_pkg::ST_READY;
              ent_d.rem   = cmd_i.mode ? {1'b0, cmd_i.slices[0]} : {1'b0, ent_q.slice};
            end else begin
              ent_d.rem = ent_q.rem - {1'b0, cmd_i.tick};
            end
          end
          // lowest level among entries ready after the charge
          if (valid_q && ent_d.st == mlq_pkg::ST_READY &&
              (!wave_i.cand || ent_q.level < wave_i.lvl)) begin
            wave_d.cand = 1'b1;
            wave_d.lvl  = ent_q.level;
          end
        end
        mlq_pkg::PS_PICK_MLQ: begin
          if (valid_q && ent_q.st == mlq_pkg::ST_READY) begin
            if (cmd_i.pick_en && ent_q.level == cmd_i.pick_lvl && !wave_i.hit) begin
              wave_d.hit = 1'b1;
              ent_d.st   = mlq_pkg::ST_RUNNING;
              ent_d.rem  = {1'b0, ent_q.slice};
            end else if (ent_q.level != 2'd0) begin
              // aging
              ent_d.level = lvl_up;
              ent_d.slice = cmd_i.slices[lvl_up];
              ent_d.rem   = {1'b0, cmd_i.slices[lvl_up]};
            end
          end
        end
        mlq_pkg::PS_PICK_RR: begin
          wave_d.flag = wave_i.flag | charged_q;
          if (valid_q && ent_q.st == mlq_pkg::ST_READY && !charged_q && !wave_i.hit &&
              (wave_i.flag || !cmd_i.after)) begin
            wave_d.hit = 1'b1;
            ent_d.st   = mlq_pkg::ST_RUNNING;
            ent_d.rem  = {1'b0, cmd_i.slices[0]};
          end
        end
        mlq_pkg::PS_REPORT: begin
          if (valid_q && ent_q.st == mlq_pkg::ST_RUNNING && !wave_i.hit) begin
            wave_d.hit  = 1'b1;
            wave_d.data = {16'd0, ent_q.pid};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q    <= '0;
      valid_q   <= 1'b0;
      charged_q <= 1'b0;
    end else begin
      wave_q    <= wave_d;
      valid_q   <= valid_d;
      charged_q <= charged_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign wave_o  = wave_q;
  assign valid_o = valid_q;
  assign ent_o   = ent_q;

endmodule

>>> rtl/multilevel_queue_task_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_queue_task_scheduler_unit: task table with MLQ / round-robin ticks
// Row of entry cells swept by a scan wave; a small sequencer runs the passes.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  in_i     in   operation, task_id, new_level, new_state, mem_limit_in
//  out_o    out  status, running_found, running_id, task_count, mem_limit_out
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
//  Each pass sends a wave down the cell row, one cell per cycle. Commands
//  take two passes, full-table creates and unused codes one pass, ticks two
//  to four. One item at a time; in_i.ready is high while the sequencer is
//  idle, also while a result waits in the output register.
//  Reset clears the valid bits and count at once; no clearing pass.
// ----------------------------------------------------------------------------
module multilevel_queue_task_scheduler_unit #(
  parameter int TABLE_ENTRIES = mlq_pkg::NumEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlq_in_if.sink      in_i,
  mlq_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // configuration
  logic            policy_q;
  logic [9:0]      tick_q;
  logic [3:0][9:0] slices_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= 1'b0;
      tick_q      <= mlq_pkg::RST_TICK;
      slices_q[0] <= mlq_pkg::RST_SLICE0;
      slices_q[1] <= mlq_pkg::RST_SLICE1;
      slices_q[2] <= mlq_pkg::RST_SLICE2;
      slices_q[3] <= mlq_pkg::RST_SLICE3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlq_pkg::CFG_POLICY: policy_q    <= cfg_data_i[0];
        mlq_pkg::CFG_TICK:   tick_q      <= cfg_data_i;
        mlq_pkg::CFG_SLICE0: slices_q[0] <= cfg_data_i;
        mlq_pkg::CFG_SLICE1: slices_q[1] <= cfg_data_i;
        mlq_pkg::CFG_SLICE2: slices_q[2] <= cfg_data_i;
        mlq_pkg::CFG_SLICE3: slices_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [1:0]    state_q, state_d;
  logic [2:0]    pass_q, pass_d;
  logic          start_q, start_d;
  logic          pick_en_q, pick_en_d;
  logic [1:0]    pick_lvl_q, pick_lvl_d;
  logic          after_q, after_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    status_q, status_d;
  logic [31:0]   lim_out_q, lim_out_d;
  logic          found_q, found_d;
  logic [15:0]   run_id_q, run_id_d;
  logic          ovalid_q, ovalid_d;

  // latched item
  logic [2:0]  op_q;
  logic [15:0] pid_q;
  logic [1:0]  lvl_q, st_q;
  logic [31:0] lim_q;

  // result register
  logic [1:0]  o_status_q;
  logic        o_found_q;
  logic [15:0] o_id_q;
  logic [4:0]  o_cnt_q;
  logic [31:0] o_lim_q;

  mlq_pkg::cmd_t   cmd;
  mlq_pkg::wave_t  wave_w  [TABLE_ENTRIES+1];
  mlq_pkg::entry_t ent_w   [TABLE_ENTRIES+1];
  logic            valid_w [TABLE_ENTRIES+1];
  mlq_pkg::wave_t  wave_end;
  logic            in_acc, load_out;

  assign in_acc   = in_i.valid && in_i.ready;
  assign wave_end = wave_w[TABLE_ENTRIES];

  always_comb begin
    cmd          = '0;
    cmd.pass     = pass_q;
    cmd.op       = op_q;
    cmd.pid      = pid_q;
    cmd.lvl      = lvl_q;
    cmd.st       = st_q;
    cmd.lim      = lim_q;
    cmd.pick_en  = pick_en_q;
    cmd.pick_lvl = pick_lvl_q;
    cmd.after    = after_q;
    cmd.mode     = policy_q;
    cmd.tick     = tick_q;
    cmd.slices   = slices_q;
  end

  // wave launched by the sequencer, one cycle long
  always_comb begin
    wave_w[0]     = '0;
    wave_w[0].act = start_q;
  end

  // cell row; the last cell closes up from an empty entry
  assign valid_w[TABLE_ENTRIES] = 1'b0;
  assign ent_w[TABLE_ENTRIES]   = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    mlq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .wave_i      (wave_w[g]),
      .nxt_valid_i (valid_w[g+1]),
      .nxt_ent_i   (ent_w[g+1]),
      .wave_o      (wave_w[g+1]),
      .valid_o     (valid_w[g]),
      .ent_o       (ent_w[g])
    );
  end

  assign load_out = (state_q == S_DONE) && (!ovalid_q || out_o.ready);

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    start_d    = 1'b0;
    pick_en_d  = pick_en_q;
    pick_lvl_d = pick_lvl_q;
    after_d    = after_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    lim_out_d  = lim_out_q;
    found_d    = found_q;
    run_id_d   = run_id_q;
    ovalid_d   = ovalid_q;
    if (ovalid_q && out_o.ready) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d   = S_RUN;
          start_d   = 1'b1;
          status_d  = mlq_pkg::STS_OK;
          lim_out_d = '0;
          after_d   = 1'b0;
          pick_en_d = 1'b0;
          case (in_i.operation) inside
            mlq_pkg::OP_CREATE: begin
              if (cnt_q == CW'(TABLE_ENTRIES)) begin
                status_d = mlq_pkg::STS_FULL;
                pass_d   = mlq_pkg::PS_REPORT;
              end else begin
                pass_d = mlq_pkg::PS_CREATE;
              end
            end
            mlq_pkg::OP_REMOVE, mlq_pkg::OP_SET_LEVEL,
            mlq_pkg::OP_SET_STATE, mlq_pkg::OP_QUERY: pass_d = mlq_pkg::PS_FIND;
            mlq_pkg::OP_TICK: pass_d = mlq_pkg::PS_CHARGE;
            default: pass_d = mlq_pkg::PS_REPORT;
          endcase
        end
      end
      S_RUN: begin
        if (wave_end.act) begin
          start_d = 1'b1;
          pass_d  = mlq_pkg::PS_REPORT;
          case (pass_q)
            mlq_pkg::PS_CREATE: cnt_d = cnt_q + CW'(1);
            mlq_pkg::PS_FIND: begin
              if (!wave_end.hit) begin
                status_d = mlq_pkg::STS_NOT_FOUND;
              end else if (op_q == mlq_pkg::OP_REMOVE) begin
                cnt_d = cnt_q - CW'(1);
              end else if (op_q == mlq_pkg::OP_QUERY) begin
                lim_out_d = wave_end.data;
              end
            end
            mlq_pkg::PS_CHARGE: begin
              if (policy_q) begin
                if (!wave_end.hit || wave_end.flag) begin
                  pass_d  = mlq_pkg::PS_PICK_RR;
                  after_d = wave_end.hit;
                end
              end else begin
                pass_d     = mlq_pkg::PS_PICK_MLQ;
                pick_en_d  = (!wave_end.hit || wave_end.flag) && wave_end.cand;
                pick_lvl_d = wave_end.lvl;
              end
            end
            mlq_pkg::PS_PICK_RR: begin
              // nothing after the expired task: wrap round to the front
              if (after_q && !wave_end.hit) begin
                pass_d  = mlq_pkg::PS_PICK_RR;
                after_d = 1'b0;
              end
            end
            mlq_pkg::PS_REPORT: begin
              start_d  = 1'b0;
              found_d  = wave_end.hit;
              run_id_d = wave_end.data[15:0];
              state_d  = S_DONE;
            end
            default: ;
          endcase
        end
      end
      S_DONE: begin
        if (load_out) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pass_q     <= mlq_pkg::PS_REPORT;
      start_q    <= 1'b0;
      pick_en_q  <= 1'b0;
      pick_lvl_q <= '0;
      after_q    <= 1'b0;
      cnt_q      <= '0;
      status_q   <= mlq_pkg::STS_OK;
      lim_out_q  <= '0;
      found_q    <= 1'b0;
      run_id_q   <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      pass_q     <= pass_d;
      start_q    <= start_d;
      pick_en_q  <= pick_en_d;
      pick_lvl_q <= pick_lvl_d;
      after_q    <= after_d;
      cnt_q      <= cnt_d;
      status_q   <= status_d;
      lim_out_q  <= lim_out_d;
      found_q    <= found_d;
      run_id_q   <= run_id_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_i.operation;
      pid_q <= in_i.task_id;
      lvl_q <= in_i.new_level;
      st_q  <= in_i.new_state;
      lim_q <= in_i.mem_limit_in;
    end
    if (load_out) begin
      o_status_q <= status_q;
      o_found_q  <= found_q;
      o_id_q     <= found_q ? run_id_q : 16'd0;
      o_cnt_q    <= 5'(cnt_q);
      o_lim_q    <= lim_out_q;
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = ovalid_q;
  assign out_o.status        = o_status_q;
  assign out_o.running_found = o_found_q;
  assign out_o.running_id    = o_id_q;
  assign out_o.task_count    = o_cnt_q;
  assign out_o.mem_limit_out = o_lim_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_wave_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wave_end.act |-> state_q == S_RUN)
    else $error("scan wave finished while sequencer not running");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_RUN && start_q)
    else $error("accepted item did not launch a pass");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_o.valid && state_q == S_IDLE)
    else $error("result not presented after report pass");

endmodule
